// File: design/arsb_pkg.sv
// ----------------------------------------------------------------------------
// arsb_pkg
// shared types, codes and helpers of the arena slot and bump allocator
// ----------------------------------------------------------------------------
package arsb_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int LOG_W     = 6;
    localparam int BUMP_W    = 33;

    localparam logic [LOG_W-1:0] LOG_LIMIT = 6'd32;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;

    localparam logic CFG_DEFAULT_LOG = 1'b0;
    localparam logic CFG_MAX_LOG     = 1'b1;

    typedef struct packed {
        logic [BUMP_W-1:0] bump;
        logic [LOG_W-1:0]  log_cap;
    } arena_entry_t;

    typedef struct packed {
        logic wr_en;
        logic load_cursor;
    } slot_cmd_t;

    function automatic logic [LOG_W-1:0] sat_log(input logic [LOG_W-1:0] v);
        return (v > LOG_LIMIT) ? LOG_LIMIT : v;
    endfunction

    // lowest clear bit, 63 when the word is full
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = BIT_W'(WORD_BITS - 1);
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                r = BIT_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// File: design/arsb_alloc_calc.sv
// ----------------------------------------------------------------------------
// arsb_alloc_calc
// bump allocation: grows log capacity to the smallest fitting power of two
// ----------------------------------------------------------------------------
module arsb_alloc_calc (
    input  arsb_pkg::arena_entry_t entry,
    input  logic [31:0]            object_size,
    input  logic [5:0]             max_log,
    output logic                   fits,
    output logic [5:0]             new_log,
    output logic [32:0]            new_bump
);
    import arsb_pkg::*;

    logic [33:0]      need;
    logic [33:0]      cap_now;
    logic             fits_now;
    logic             fit_any;
    logic [LOG_W-1:0] kmin;
    logic [LOG_W-1:0] mx;

    always_comb begin
        need     = 34'(entry.bump) + 34'(object_size);
        cap_now  = 34'(1) << entry.log_cap;
        fits_now = (need <= cap_now) || (34'(entry.bump) > cap_now);
        mx       = sat_log(max_log);
        kmin     = '0;
        fit_any  = 1'b0;
        for (int k = 32; k >= 0; k--) begin
            if (need <= (34'(1) << k)) begin
                kmin    = LOG_W'(k);
                fit_any = 1'b1;
            end
        end
        fits     = fits_now || (fit_any && (kmin <= mx));
        new_log  = fits_now ? entry.log_cap : kmin;
        new_bump = need[32:0];
    end

endmodule

// File: design/arsb_slot_map.sv
// ----------------------------------------------------------------------------
// arsb_slot_map
// occupancy bitmap memory, per-word full flags, rotating cursor, word pick
// ----------------------------------------------------------------------------
module arsb_slot_map #(
    parameter int WORD_COUNT = 4,
    parameter int WORD_W     = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [WORD_W-1:0]    rd_word,
    output logic [63:0]          rd_data,
    input  arsb_pkg::slot_cmd_t  cmd,
    input  logic [WORD_W-1:0]    wr_word,
    input  logic [63:0]          wr_data,
    output logic [WORD_W-1:0]    pick_word,
    output logic                 any_free
);
    import arsb_pkg::*;

    logic [WORD_BITS-1:0]  bm_mem [WORD_COUNT];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic [WORD_COUNT-1:0] full_reg;
    logic [WORD_W-1:0]     cursor_reg;
    logic [WORD_COUNT-1:0] not_full;
    logic [WORD_COUNT-1:0] upper;
    logic [WORD_W-1:0]     pick_upper;
    logic [WORD_W-1:0]     pick_any;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            bm_mem[wr_word] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= bm_mem[rd_word];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg   <= '0;
            cursor_reg <= '0;
        end else begin
            if (cmd.wr_en) begin
                full_reg[wr_word] <= &wr_data;
            end
            if (cmd.load_cursor) begin
                cursor_reg <= wr_word;
            end
        end
    end

    // first non-full word at or after the cursor, else the first overall
    always_comb begin
        not_full   = ~full_reg;
        pick_upper = '0;
        pick_any   = '0;
        for (int w = 0; w < WORD_COUNT; w++) begin
            upper[w] = not_full[w] && (WORD_W'(w) >= cursor_reg);
        end
        for (int w = WORD_COUNT - 1; w >= 0; w--) begin
            if (upper[w]) begin
                pick_upper = WORD_W'(w);
            end
            if (not_full[w]) begin
                pick_any = WORD_W'(w);
            end
        end
        pick_word = (|upper) ? pick_upper : pick_any;
        any_free  = |not_full;
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/arena_slot_and_bump_allocator.sv
// ----------------------------------------------------------------------------
// arena_slot_and_bump_allocator
// arena slot registry with a bump allocator per arena
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   opcode, arena index, size, type
//   m_       out        m_valid / m_ready   arena, offset, type, log cap, status
//   cfg_     in         cfg_wr_en           register index, write data
//
// a request is read, then executed: the accept edge reads the arena entry and the
// bitmap word, the execute step modifies, writes back and loads the result
// the rate is set by the read-modify-write of the arena and bitmap memories
// after reset a clearing pass over every arena entry zeroes the memories with
// s_ready low
// with m_ready low a finished request waits until the result register frees
// ----------------------------------------------------------------------------
module arena_slot_and_bump_allocator #(
    parameter int ARENA_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_arena_index,
    input  logic [31:0] s_object_size,
    input  logic [7:0]  s_reference_type,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_arena,
    output logic [31:0] m_result_offset,
    output logic [7:0]  m_result_type,
    output logic [5:0]  m_result_log_capacity,
    output logic [1:0]  m_status
);
    import arsb_pkg::*;

    localparam int WORD_COUNT = ARENA_COUNT / WORD_BITS;
    localparam int SLOT_COUNT = WORD_COUNT * WORD_BITS;
    localparam int ID_W       = $clog2(SLOT_COUNT);
    localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ID_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LOG_W-1:0]  def_log_reg;
    logic [LOG_W-1:0]  max_log_reg;

    logic [1:0]        op_reg;
    logic [7:0]        idx_reg;
    logic [31:0]       size_reg;
    logic [7:0]        type_reg;
    logic [WORD_W-1:0] pick_word_reg;
    logic              any_free_reg;

    arena_entry_t      arena_mem [SLOT_COUNT];
    arena_entry_t      arena_rd_reg;

    logic              m_valid_reg;
    logic [7:0]        m_arena_reg;
    logic [31:0]       m_offset_reg;
    logic [7:0]        m_type_reg;
    logic [LOG_W-1:0]  m_log_reg;
    logic [1:0]        m_status_reg;

    logic              clearing;
    logic              s_accept;
    logic              out_free;
    logic              exec_fire;
    logic              in_range;

    logic [WORD_W-1:0] pick_word;
    logic              any_free;
    logic [WORD_W-1:0] bm_rd_word;
    logic [63:0]       bm_rd;
    slot_cmd_t         slot_cmd;
    logic [WORD_W-1:0] bm_wr_word;
    logic [63:0]       bm_wr_data;
    logic [WORD_W-1:0] ex_bm_word;
    logic [63:0]       ex_bm_data;
    logic              ex_bm_go;
    logic              ex_cur_load;

    logic              ar_wr_en;
    logic [ID_W-1:0]   ar_wr_addr;
    arena_entry_t      ar_wr_data;
    logic [ID_W-1:0]   ex_ar_addr;
    arena_entry_t      ex_ar_data;
    logic              ex_ar_go;

    logic              alloc_fits;
    logic [LOG_W-1:0]  alloc_log;
    logic [32:0]       alloc_bump;
    logic [BIT_W-1:0]  create_bit;
    logic [ID_W-1:0]   new_id;
    logic [LOG_W-1:0]  def_sat;

    logic [7:0]        res_arena;
    logic [31:0]       res_offset;
    logic [LOG_W-1:0]  res_log;
    logic [1:0]        res_status;

    assign clearing  = (state_reg == S_CLEAR);
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign in_range  = (32'(idx_reg) < 32'(SLOT_COUNT));
    assign def_sat   = sat_log(def_log_reg);
    assign create_bit = first_zero(bm_rd);
    assign new_id    = ID_W'({pick_word_reg, create_bit});

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_log_reg <= 6'd10;
            max_log_reg <= 6'd20;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEFAULT_LOG: def_log_reg <= cfg_wdata;
                CFG_MAX_LOG:     max_log_reg <= cfg_wdata;
            endcase
        end
    end

    // control
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == ID_W'(SLOT_COUNT - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg        <= s_opcode;
            idx_reg       <= s_arena_index;
            size_reg      <= s_object_size;
            type_reg      <= s_reference_type;
            pick_word_reg <= pick_word;
            any_free_reg  <= any_free;
        end
    end

    // arena state memory
    always_ff @(posedge aclk) begin
        if (ar_wr_en) begin
            arena_mem[ar_wr_addr] <= ar_wr_data;
        end
        if (s_accept) begin
            arena_rd_reg <= arena_mem[ID_W'(s_arena_index)];
        end
    end

    assign bm_rd_word = (s_opcode == OP_CREATE) ? pick_word : WORD_W'(s_arena_index[7:6]);

    arsb_slot_map #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_W     (WORD_W)
    ) u_slot_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_word   (bm_rd_word),
        .rd_data   (bm_rd),
        .cmd       (slot_cmd),
        .wr_word   (bm_wr_word),
        .wr_data   (bm_wr_data),
        .pick_word (pick_word),
        .any_free  (any_free)
    );

    arsb_alloc_calc u_alloc_calc (
        .entry       (arena_rd_reg),
        .object_size (size_reg),
        .max_log     (max_log_reg),
        .fits        (alloc_fits),
        .new_log     (alloc_log),
        .new_bump    (alloc_bump)
    );

    // modify step
    always_comb begin
        res_arena   = idx_reg;
        res_offset  = '0;
        res_log     = '0;
        res_status  = ST_OK;
        ex_ar_addr  = ID_W'(idx_reg);
        ex_ar_data  = '0;
        ex_ar_go    = 1'b0;
        ex_bm_word  = WORD_W'(idx_reg[7:6]);
        ex_bm_data  = bm_rd;
        ex_bm_go    = 1'b0;
        ex_cur_load = 1'b0;
        case (op_reg)
            OP_CREATE: begin
                res_arena = '0;
                if (any_free_reg) begin
                    res_arena          = 8'(new_id);
                    res_log            = def_sat;
                    ex_bm_word         = pick_word_reg;
                    ex_bm_data         = bm_rd | (64'(1) << create_bit);
                    ex_bm_go           = 1'b1;
                    ex_cur_load        = 1'b1;
                    ex_ar_addr         = new_id;
                    ex_ar_data.log_cap = def_sat;
                    ex_ar_go           = 1'b1;
                end else begin
                    res_status = ST_NO_SLOT;
                end
            end
            OP_ALLOC: begin
                if (in_range) begin
                    if (alloc_fits) begin
                        res_offset         = arena_rd_reg.bump[31:0];
                        res_log            = alloc_log;
                        ex_ar_data.bump    = alloc_bump;
                        ex_ar_data.log_cap = alloc_log;
                        ex_ar_go           = 1'b1;
                    end else begin
                        res_status = ST_OVER;
                        res_log    = arena_rd_reg.log_cap;
                    end
                end
            end
            OP_FREE: begin
                if (in_range) begin
                    ex_bm_data = bm_rd & ~(64'(1) << idx_reg[5:0]);
                    ex_bm_go   = 1'b1;
                    ex_ar_go   = 1'b1;
                end
            end
            default: begin
                if (in_range) begin
                    res_log            = arena_rd_reg.log_cap;
                    ex_ar_data.log_cap = arena_rd_reg.log_cap;
                    ex_ar_go           = 1'b1;
                end
            end
        endcase
    end

    // write ports, clearing pass has priority
    always_comb begin
        ar_wr_en             = clearing || (exec_fire && ex_ar_go);
        ar_wr_addr           = clearing ? clr_cnt_reg : ex_ar_addr;
        ar_wr_data           = clearing ? '0 : ex_ar_data;
        slot_cmd.wr_en       = clearing ? (32'(clr_cnt_reg) < 32'(WORD_COUNT))
                                        : (exec_fire && ex_bm_go);
        slot_cmd.load_cursor = !clearing && exec_fire && ex_cur_load;
        bm_wr_word           = clearing ? WORD_W'(clr_cnt_reg) : ex_bm_word;
        bm_wr_data           = clearing ? '0 : ex_bm_data;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_arena_reg  <= res_arena;
            m_offset_reg <= res_offset;
            m_type_reg   <= type_reg;
            m_log_reg    <= res_log;
            m_status_reg <= res_status;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_result_arena        = m_arena_reg;
    assign m_result_offset       = m_offset_reg;
    assign m_result_type         = m_type_reg;
    assign m_result_log_capacity = m_log_reg;
    assign m_status              = m_status_reg;

`ifndef SYNTHESIS
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass restarted");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    a_no_slot_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_NO_SLOT))
            |-> (m_arena_reg == 8'd0) && (m_log_reg == 6'd0))
        else $error("full registry result not zeroed");

    a_log_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_log_reg <= LOG_LIMIT))
        else $error("log capacity above limit");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) && !out_free |=> $stable(m_arena_reg) && m_valid_reg)
        else $error("pending result overwritten");
`endif

endmodule

// File: verif/arena_slot_and_bump_allocator_tb.sv
// ----------------------------------------------------------------------------
// arena_slot_and_bump_allocator_tb
// self-checking bench for the arena slot registry and bump allocator
//
// a tracker class keeps its own copy of the slot bitmap, the search cursor
// and each arena's bump pointer and log capacity. it predicts one result per
// accepted request and checks the results in order. directed requests cover
// capacity growth, oversize allocs, the bump pointer reaching 2^32 and stale
// arenas. random phases run under several register settings and mix create,
// alloc, free and clear with a full registry fill. both sides idle at random,
// and the result side holds off once for a long stretch
// ----------------------------------------------------------------------------
module arena_slot_and_bump_allocator_tb;
    import arsb_pkg::*;

    localparam int ARENA_SLOTS = 256;
    localparam int WORDS       = ARENA_SLOTS / WORD_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  arena_index;
        logic [31:0] object_size;
        logic [7:0]  reference_type;
    } request_t;

    typedef struct packed {
        logic [7:0]  arena;
        logic [31:0] offset;
        logic [7:0]  rtype;
        logic [5:0]  log_cap;
        logic [1:0]  status;
    } grant_t;

    class arena_tracker;
        logic [WORD_BITS-1:0] occupancy [WORDS];
        int unsigned          cursor;
        logic [BUMP_W-1:0]    bump [ARENA_SLOTS];
        logic [LOG_W-1:0]     log_cap [ARENA_SLOTS];
        logic [LOG_W-1:0]     default_log;
        logic [LOG_W-1:0]     max_log;
        grant_t               pending_grants [$];
        int                   mismatches;
        int                   grants_checked;
        int                   no_slot_count;
        int                   overflow_count;

        function new();
            foreach (occupancy[w]) begin
                occupancy[w] = '0;
            end
            foreach (bump[a]) begin
                bump[a]    = '0;
                log_cap[a] = '0;
            end
            cursor         = 0;
            default_log    = 6'd10;
            max_log        = 6'd20;
            mismatches     = 0;
            grants_checked = 0;
            no_slot_count  = 0;
            overflow_count = 0;
        endfunction

        function void set_register(logic idx, logic [LOG_W-1:0] value);
            if (idx == CFG_DEFAULT_LOG) begin
                default_log = value;
            end else begin
                max_log = value;
            end
        endfunction

        function void note_request(request_t r);
            grant_t           g;
            int               w;
            int               b;
            int               slot;
            bit               found;
            logic [LOG_W-1:0] lg;
            logic [LOG_W-1:0] mx;
            logic [63:0]      cap;
            logic [63:0]      bp;
            g.arena   = r.arena_index;
            g.offset  = '0;
            g.rtype   = r.reference_type;
            g.log_cap = '0;
            g.status  = ST_OK;
            if (r.opcode == OP_CREATE) begin
                g.arena = '0;
                found   = 1'b0;
                for (int i = 0; i < WORDS && !found; i++) begin
                    w = (cursor + i) % WORDS;
                    if (~occupancy[w] != '0) begin
                        b = 0;
                        while (b < WORD_BITS - 1 && occupancy[w][b]) begin
                            b++;
                        end
                        slot             = w * WORD_BITS + b;
                        cursor           = w;
                        occupancy[w][b]  = 1'b1;
                        bump[slot]       = '0;
                        log_cap[slot]    = (default_log > LOG_LIMIT) ? LOG_LIMIT : default_log;
                        g.arena          = slot[7:0];
                        g.log_cap        = log_cap[slot];
                        found            = 1'b1;
                    end
                end
                if (!found) begin
                    g.status = ST_NO_SLOT;
                end
            end else if (int'(r.arena_index) < ARENA_SLOTS) begin
                case (r.opcode)
                    OP_ALLOC: begin
                        lg  = log_cap[r.arena_index];
                        mx  = (max_log > LOG_LIMIT) ? LOG_LIMIT : max_log;
                        cap = 64'd1 << lg;
                        bp  = 64'(bump[r.arena_index]);
                        while (cap - bp < 64'(r.object_size) && lg < mx) begin
                            cap = cap << 1;
                            lg++;
                        end
                        if (cap - bp < 64'(r.object_size)) begin
                            g.status  = ST_OVER;
                            g.log_cap = log_cap[r.arena_index];
                        end else begin
                            log_cap[r.arena_index] = lg;
                            bump[r.arena_index]    = BUMP_W'(bp + 64'(r.object_size));
                            g.offset               = bp[31:0];
                            g.log_cap              = lg;
                        end
                    end
                    OP_FREE: begin
                        occupancy[r.arena_index / WORD_BITS][r.arena_index % WORD_BITS] = 1'b0;
                        bump[r.arena_index]    = '0;
                        log_cap[r.arena_index] = '0;
                    end
                    default: begin
                        bump[r.arena_index] = '0;
                        g.log_cap           = log_cap[r.arena_index];
                    end
                endcase
            end
            if (g.status == ST_NO_SLOT) begin
                no_slot_count++;
            end
            if (g.status == ST_OVER) begin
                overflow_count++;
            end
            pending_grants.push_back(g);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (mismatches < PRINT_LIMIT) begin
                    $display("%0t %s mismatch: expected %0h, got %0h", $time, field, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (pending_grants.size() == 0) begin
                if (mismatches < PRINT_LIMIT) begin
                    $display("%0t unexpected result: expected none, got arena %0d status %0d",
                             $time, got.arena, got.status);
                end
                mismatches++;
                return;
            end
            want = pending_grants.pop_front();
            grants_checked++;
            compare_field("result_arena", 32'(want.arena), 32'(got.arena));
            compare_field("result_offset", want.offset, got.offset);
            compare_field("result_type", 32'(want.rtype), 32'(got.rtype));
            compare_field("result_log_capacity", 32'(want.log_cap), 32'(got.log_cap));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function logic [7:0] pick_live();
            int start;
            int a;
            start = $urandom_range(0, ARENA_SLOTS - 1);
            for (int i = 0; i < ARENA_SLOTS; i++) begin
                a = (start + i) % ARENA_SLOTS;
                if (occupancy[a / WORD_BITS][a % WORD_BITS]) begin
                    return a[7:0];
                end
            end
            return start[7:0];
        endfunction

        function logic [31:0] room_left(logic [7:0] idx);
            return 32'((64'd1 << log_cap[idx]) - 64'(bump[idx]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [7:0]  s_arena_index;
    logic [31:0] s_object_size;
    logic [7:0]  s_reference_type;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_result_arena;
    logic [31:0] m_result_offset;
    logic [7:0]  m_result_type;
    logic [5:0]  m_result_log_capacity;
    logic [1:0]  m_status;

    arena_tracker tracker;
    int           cycle_count;
    int           requests_sent;
    int           settings_used;
    bit           send_steady;

    always #5 aclk = ~aclk;

    arena_slot_and_bump_allocator #(
        .ARENA_COUNT(ARENA_SLOTS)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_arena_index        (s_arena_index),
        .s_object_size        (s_object_size),
        .s_reference_type     (s_reference_type),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_arena       (m_result_arena),
        .m_result_offset      (m_result_offset),
        .m_result_type        (m_result_type),
        .m_result_log_capacity(m_result_log_capacity),
        .m_status             (m_status)
    );

    function automatic int pick_gap(bit steady);
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_size(logic [7:0] idx);
        int          roll;
        logic [31:0] room;
        roll = $urandom_range(0, 99);
        room = tracker.room_left(idx);
        if (roll < 30) begin
            return $urandom_range(0, 64);
        end
        if (roll < 50) begin
            return $urandom_range(0, 4096);
        end
        if (roll < 70) begin
            return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
        end
        // exact fit, or one past it to force growth
        if (roll < 85) begin
            return room + $urandom_range(0, 1);
        end
        if (roll < 95) begin
            return $urandom;
        end
        return 32'd0;
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [7:0] idx,
                                input logic [31:0] size, input logic [7:0] typ);
        int       gap;
        request_t r;
        gap = pick_gap(send_steady);
        r   = '{op, idx, size, typ};
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_arena_index    <= idx;
        s_object_size    <= size;
        s_reference_type <= typ;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_request(r);
        requests_sent++;
        if (requests_sent % 100 == 0) begin
            send_steady = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic random_request();
        int         roll;
        logic [7:0] idx;
        roll = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : tracker.pick_live();
        if (roll < 22) begin
            push_request(OP_CREATE, 8'($urandom), $urandom, 8'($urandom));
        end else if (roll < 65) begin
            push_request(OP_ALLOC, idx, pick_size(idx), 8'($urandom));
        end else if (roll < 80) begin
            push_request(OP_FREE, idx, $urandom, 8'($urandom));
        end else if (roll < 92) begin
            push_request(OP_CLEAR, idx, $urandom, 8'($urandom));
        end else begin
            push_request(2'($urandom), 8'($urandom), $urandom, 8'($urandom));
        end
    endtask

    task automatic drain_grants();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending_grants.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [5:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_register(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [5:0] dflt, input logic [5:0] mx);
        drain_grants();
        write_register(CFG_DEFAULT_LOG, dflt);
        write_register(CFG_MAX_LOG, mx);
        settings_used++;
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : result_side
        int     stall_left;
        bit     held;
        bit     steady;
        grant_t seen;
        stall_left = 0;
        held       = 1'b0;
        steady     = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                seen = {m_result_arena, m_result_offset, m_result_type,
                        m_result_log_capacity, m_status};
                tracker.check_grant(seen);
                // one long hold so the block backs up and stalls requests
                if (!held && tracker.grants_checked == 600) begin
                    stall_left = HOLD_CYCLES;
                    held       = 1'b1;
                end else begin
                    if (tracker.grants_checked % 120 == 0) begin
                        steady = ($urandom_range(0, 3) == 0);
                    end
                    stall_left = pick_gap(steady);
                end
            end
        end
    end

    initial begin : stimulus
        logic [5:0] dflt;
        logic [5:0] mx;
        int         count;
        tracker          = new();
        requests_sent    = 0;
        settings_used    = 1;
        send_steady      = 1'b0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_opcode         = OP_CREATE;
        s_arena_index    = '0;
        s_object_size    = '0;
        s_reference_type = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // register values after reset
        push_request(OP_CREATE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        push_request(OP_ALLOC, 8'd0, 32'd0, 8'h00);
        push_request(OP_ALLOC, 8'd0, 32'd1024, 8'h5A);
        push_request(OP_ALLOC, 8'd0, 32'd1, 8'hA5);
        push_request(OP_ALLOC, 8'd0, 32'hFFFF_FFFF, 8'h01);
        push_request(OP_CLEAR, 8'd0, 32'd0, 8'h02);
        push_request(OP_ALLOC, 8'd0, 32'h0010_0000, 8'h03);
        push_request(OP_FREE, 8'd0, 32'd0, 8'h04);
        push_request(OP_FREE, 8'd0, 32'd0, 8'h05);
        push_request(OP_ALLOC, 8'd255, 32'd1, 8'h06);
        push_request(OP_CLEAR, 8'd200, 32'hFFFF_FFFF, 8'h07);
        push_request(OP_CREATE, 8'd0, 32'd0, 8'h08);

        // full 2^32 capacity, bump pointer runs up to 2^32
        configure(6'd32, 6'd32);
        push_request(OP_CREATE, 8'd0, 32'd0, 8'h10);
        push_request(OP_ALLOC, 8'd1, 32'hFFFF_FFFF, 8'h11);
        push_request(OP_ALLOC, 8'd1, 32'd1, 8'h12);
        push_request(OP_ALLOC, 8'd1, 32'd0, 8'h13);
        push_request(OP_ALLOC, 8'd1, 32'd1, 8'h14);
        push_request(OP_CLEAR, 8'd1, 32'd0, 8'h15);
        push_request(OP_ALLOC, 8'd255, 32'h8000_0000, 8'h16);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    dflt  = 6'd32;
                    mx    = 6'd32;
                    count = 250;
                end
                1: begin
                    dflt  = 6'd63;
                    mx    = 6'd63;
                    count = 200;
                end
                2: begin
                    dflt  = 6'd0;
                    mx    = 6'd0;
                    count = 250;
                end
                3: begin
                    dflt  = 6'd40;
                    mx    = 6'd5;
                    count = 250;
                end
                default: begin
                    dflt  = 6'($urandom);
                    mx    = 6'($urandom);
                    count = 160;
                end
            endcase
            configure(dflt, mx);
            // fill the registry and run past full
            if (p == 1) begin
                repeat (ARENA_SLOTS + 6) begin
                    push_request(OP_CREATE, 8'($urandom), $urandom, 8'($urandom));
                end
            end
            repeat (count) begin
                random_request();
            end
        end

        drain_grants();
        $display("covered %0d requests under %0d register settings, %0d results checked",
                 requests_sent, settings_used, tracker.grants_checked);
        $display("outcomes included %0d creates on a full registry and %0d oversize allocs",
                 tracker.no_slot_count, tracker.overflow_count);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/arsb_pkg.sv
design/arsb_alloc_calc.sv
design/arsb_slot_map.sv
design/arena_slot_and_bump_allocator.sv
verif/arena_slot_and_bump_allocator_tb.sv
